### rtl/hlvp_pkg.sv
// ----------------------------------------------------------------------------
// hlvp_pkg
// Shared sizes, codes and payload types of the Hough line voting engine.
// ----------------------------------------------------------------------------
package hlvp_pkg;

   localparam int THETA_BINS     = 256;
   localparam int RHO_BINS       = 2048;
   localparam int COORD_BITS     = 9;
   localparam int TRIG_FRAC_BITS = 14;

   localparam int THETA_W  = $clog2(THETA_BINS);
   localparam int RHO_W    = $clog2(RHO_BINS);
   localparam int ADDR_W   = THETA_W + RHO_W;
   localparam int NA_W     = $clog2(THETA_BINS + 1);
   localparam int NR_W     = $clog2(RHO_BINS + 1);

   // Datapath widths of the rho computation.
   localparam int PROD_W      = COORD_BITS + 17;
   localparam int SUM_W       = PROD_W + 1;
   localparam int SCALED_W    = SUM_W + 17;
   localparam int SCALE_SHIFT = TRIG_FRAC_BITS + 8;
   localparam int IDX_W       = SCALED_W - SCALE_SHIFT + 2;

   localparam logic signed [SCALED_W:0] ROUND_HALF =
      (SCALED_W + 1)'(1) << (SCALE_SHIFT - 1);

   localparam logic [15:0] VOTE_MAX = 16'hFFFF;

   localparam logic [8:0]  ANGLE_COUNT_RST    = 9'd180;
   localparam logic [11:0] RHO_COUNT_RST      = 12'd1447;
   localparam logic [15:0] INV_RHO_STEP_RST   = 16'd256;
   localparam logic [15:0] VOTE_THRESHOLD_RST = 16'd100;

   typedef enum logic [1:0] {
      KIND_LOAD  = 2'd0,
      KIND_VOTE  = 2'd1,
      KIND_SCAN  = 2'd2,
      KIND_CLEAR = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_DROPPED = 2'd1,
      STATUS_RANGE   = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      CSR_ANGLE_COUNT    = 2'd0,
      CSR_RHO_COUNT      = 2'd1,
      CSR_INV_RHO_STEP   = 2'd2,
      CSR_VOTE_THRESHOLD = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_VOTE,
      ST_DRAIN,
      ST_SCAN
   } state_type;

   typedef struct packed {
      logic [1:0]         kind;
      logic [8:0]         pixel_x;
      logic [8:0]         pixel_y;
      logic [7:0]         angle_index;
      logic signed [15:0] cos_value;
      logic signed [15:0] sin_value;
      logic [10:0]        cell_rho;
   } req_type;

   typedef struct packed {
      logic [15:0]        votes;
      logic               above_threshold;
      logic [15:0]        best_votes;
      logic [10:0]        best_rho;
      logic [7:0]         best_theta;
      logic signed [11:0] signed_rho_bin;
      logic [1:0]         status;
   } rsp_type;

   typedef struct packed {
      logic signed [15:0] cos_value;
      logic signed [15:0] sin_value;
   } trig_type;

   // One accumulator cell coming out of the rho pipeline.
   typedef struct packed {
      logic               valid;
      logic               in_range;
      logic [THETA_W-1:0] theta;
      logic [RHO_W-1:0]   rho;
   } cell_type;

endpackage

### rtl/hlvp_angle_ram.sv
// ----------------------------------------------------------------------------
// hlvp_angle_ram
// Cosine/sine table, one write and one registered read port.
// ----------------------------------------------------------------------------
module hlvp_angle_ram (
   input  logic                       clock,
   input  logic                       we,
   input  logic [hlvp_pkg::THETA_W-1:0] waddr,
   input  hlvp_pkg::trig_type         wdata,
   input  logic [hlvp_pkg::THETA_W-1:0] raddr,
   output hlvp_pkg::trig_type         rdata
);

   hlvp_pkg::trig_type mem [hlvp_pkg::THETA_BINS];
   hlvp_pkg::trig_type rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

### rtl/hlvp_vote_ram.sv
// ----------------------------------------------------------------------------
// hlvp_vote_ram
// Accumulator store, one write and one registered read port.
// ----------------------------------------------------------------------------
module hlvp_vote_ram (
   input  logic                        clock,
   input  logic                        we,
   input  logic [hlvp_pkg::ADDR_W-1:0] waddr,
   input  logic [15:0]                 wdata,
   input  logic [hlvp_pkg::ADDR_W-1:0] raddr,
   output logic [15:0]                 rdata
);

   logic [15:0] mem [2 ** hlvp_pkg::ADDR_W];
   logic [15:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

### rtl/hlvp_rho_calc.sv
// ----------------------------------------------------------------------------
// hlvp_rho_calc
// Pipeline from an angle index to an accumulator cell: products, sum,
// scale, round and offset, one angle entering per cycle.
// ----------------------------------------------------------------------------
module hlvp_rho_calc (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            issue_valid,
   input  logic [hlvp_pkg::THETA_W-1:0]    issue_theta,
   input  hlvp_pkg::trig_type              trig,
   input  logic [hlvp_pkg::COORD_BITS-1:0] x,
   input  logic [hlvp_pkg::COORD_BITS-1:0] y,
   input  logic [15:0]                     inv_step,
   input  logic [hlvp_pkg::NR_W-1:0]       half,
   input  logic [hlvp_pkg::NR_W-1:0]       nr,
   output hlvp_pkg::cell_type              hit,
   output logic                            busy
);

   logic                                 va_ff, vb_ff, vc_ff, vd_ff;
   logic [hlvp_pkg::THETA_W-1:0]         ta_ff, tb_ff, tc_ff, td_ff;
   logic signed [hlvp_pkg::PROD_W-1:0]   px_ff, py_ff, px_in, py_in;
   logic signed [hlvp_pkg::SUM_W-1:0]    sum_ff, sum_in;
   logic signed [hlvp_pkg::SCALED_W-1:0] scaled_ff, scaled_in;
   logic signed [hlvp_pkg::SCALED_W:0]   rounded, shifted;
   logic signed [hlvp_pkg::IDX_W-1:0]    idx;
   hlvp_pkg::cell_type                   cell_ff, cell_in;

   always_comb begin
      px_in     = $signed({1'b0, x}) * trig.cos_value;
      py_in     = $signed({1'b0, y}) * trig.sin_value;
      sum_in    = hlvp_pkg::SUM_W'(px_ff) + hlvp_pkg::SUM_W'(py_ff);
      scaled_in = sum_ff * $signed({1'b0, inv_step});
      // round half up, then floor through the arithmetic shift
      rounded   = {scaled_ff[hlvp_pkg::SCALED_W-1], scaled_ff} + hlvp_pkg::ROUND_HALF;
      shifted   = rounded >>> hlvp_pkg::SCALE_SHIFT;
      idx       = hlvp_pkg::IDX_W'(shifted)
                  + $signed(hlvp_pkg::IDX_W'({1'b0, half}));
      cell_in.valid    = vd_ff;
      cell_in.in_range = !idx[hlvp_pkg::IDX_W-1]
                         && (idx < $signed(hlvp_pkg::IDX_W'({1'b0, nr})));
      cell_in.theta    = td_ff;
      cell_in.rho      = hlvp_pkg::RHO_W'(idx);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff         <= 1'b0;
         vb_ff         <= 1'b0;
         vc_ff         <= 1'b0;
         vd_ff         <= 1'b0;
         cell_ff.valid <= 1'b0;
      end else begin
         va_ff         <= issue_valid;
         vb_ff         <= va_ff;
         vc_ff         <= vb_ff;
         vd_ff         <= vc_ff;
         cell_ff.valid <= cell_in.valid;
      end
      ta_ff            <= issue_theta;
      tb_ff            <= ta_ff;
      tc_ff            <= tb_ff;
      td_ff            <= tc_ff;
      px_ff            <= px_in;
      py_ff            <= py_in;
      sum_ff           <= sum_in;
      scaled_ff        <= scaled_in;
      cell_ff.in_range <= cell_in.in_range;
      cell_ff.theta    <= cell_in.theta;
      cell_ff.rho      <= cell_in.rho;
   end

   assign hit  = cell_ff;
   assign busy = va_ff | vb_ff | vc_ff | vd_ff | cell_ff.valid;

endmodule

### rtl/hough_line_vote_and_peak.sv
// ----------------------------------------------------------------------------
// hough_line_vote_and_peak
// Hough line voting engine with cell scan and best-line tracker.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; every request gives
// exactly one response, shown for one cycle with rsp_valid, and the receiver
// cannot stall it. A vote sends one angle per cycle through the rho pipeline
// and a read-modify-write of the accumulator memory, then drains that
// pipeline. A clear sweeps the accumulator memory one cell per cycle; after
// reset the same clearing pass runs with busy high and no response.
// Configuration writes are taken at any time.
// ----------------------------------------------------------------------------
module hough_line_vote_and_peak (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  hlvp_pkg::req_type req_data,
   output logic              rsp_valid,
   output hlvp_pkg::rsp_type rsp_data,
   input  logic              csr_we,
   input  logic [1:0]        csr_index,
   input  logic [15:0]       csr_wdata
);

   // Configuration registers.
   logic [8:0]  angle_count_ff;
   logic [11:0] rho_count_ff;
   logic [15:0] inv_rho_step_ff;
   logic [15:0] vote_threshold_ff;

   hlvp_pkg::state_type state_ff, state_in;
   logic [hlvp_pkg::THETA_W-1:0]    issue_ff, issue_in;
   logic [hlvp_pkg::COORD_BITS-1:0] x_ff, x_in, y_ff, y_in;
   logic [hlvp_pkg::THETA_W-1:0]    scan_theta_ff, scan_theta_in;
   logic [hlvp_pkg::RHO_W-1:0]      scan_rho_ff, scan_rho_in;
   logic [hlvp_pkg::ADDR_W-1:0]     clr_addr_ff, clr_addr_in;
   logic                            clr_report_ff, clr_report_in;
   logic                            drop_ff, drop_in;
   logic [15:0]                     best_votes_ff, best_votes_in;
   logic [hlvp_pkg::RHO_W-1:0]      best_rho_ff, best_rho_in;
   logic [hlvp_pkg::THETA_W-1:0]    best_theta_ff, best_theta_in;
   logic                            w_valid_ff, w_valid_in;
   logic [hlvp_pkg::ADDR_W-1:0]     w_addr_ff, w_addr_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   hlvp_pkg::rsp_type               rsp_ff, rsp_in;

   logic [hlvp_pkg::NA_W-1:0] na;
   logic [hlvp_pkg::NR_W-1:0] nr, half;
   logic                      accept;
   logic                      issue_valid;
   logic                      pipe_busy, rc_busy;
   hlvp_pkg::cell_type        hit;
   hlvp_pkg::trig_type        trig, trig_wdata;
   logic                      angle_we;
   logic [hlvp_pkg::THETA_W-1:0] angle_waddr;
   logic                      vram_we;
   logic [hlvp_pkg::ADDR_W-1:0] vram_waddr, vram_raddr;
   logic [15:0]               vram_wdata, vram_rdata;
   logic [hlvp_pkg::THETA_W-1:0] req_theta;
   logic [hlvp_pkg::RHO_W-1:0]   req_rho;
   logic                      req_load_ok, req_scan_ok;
   logic [15:0]               votes;
   logic                      above;
   logic signed [11:0]        srho;
   hlvp_pkg::status_type      status;

   // Effective sizes: counts above the array size act as the array size.
   always_comb begin
      na   = (32'(angle_count_ff) > hlvp_pkg::THETA_BINS)
             ? hlvp_pkg::NA_W'(hlvp_pkg::THETA_BINS) : hlvp_pkg::NA_W'(angle_count_ff);
      nr   = (32'(rho_count_ff) > hlvp_pkg::RHO_BINS)
             ? hlvp_pkg::NR_W'(hlvp_pkg::RHO_BINS) : hlvp_pkg::NR_W'(rho_count_ff);
      half = nr >> 1;
   end

   assign busy      = (state_ff != hlvp_pkg::ST_IDLE);
   assign accept    = start && !busy;
   assign pipe_busy = rc_busy || w_valid_ff;

   assign req_theta   = hlvp_pkg::THETA_W'(req_data.angle_index);
   assign req_rho     = hlvp_pkg::RHO_W'(req_data.cell_rho);
   assign req_load_ok = 32'(req_data.angle_index) < hlvp_pkg::THETA_BINS;
   assign req_scan_ok = (32'(req_data.angle_index) < 32'(na))
                        && (32'(req_data.cell_rho) < 32'(nr));

   // Load writes the table on the accept edge.
   assign angle_we          = accept && (req_data.kind == hlvp_pkg::KIND_LOAD) && req_load_ok;
   assign angle_waddr       = req_theta;
   assign trig_wdata.cos_value = req_data.cos_value;
   assign trig_wdata.sin_value = req_data.sin_value;

   hlvp_angle_ram u_angle_ram (
      .clock (clock),
      .we    (angle_we),
      .waddr (angle_waddr),
      .wdata (trig_wdata),
      .raddr (issue_ff),
      .rdata (trig)
   );

   assign issue_valid = (state_ff == hlvp_pkg::ST_VOTE);

   hlvp_rho_calc u_rho_calc (
      .clock       (clock),
      .reset       (reset),
      .issue_valid (issue_valid),
      .issue_theta (issue_ff),
      .trig        (trig),
      .x           (x_ff),
      .y           (y_ff),
      .inv_step    (inv_rho_step_ff),
      .half        (half),
      .nr          (nr),
      .hit         (hit),
      .busy        (rc_busy)
   );

   // Accumulator ports. Reads: the scanned cell while idle, otherwise the
   // cell leaving the rho pipeline. Writes: the clearing sweep or the
   // incremented count in the cycle after its read. Consecutive cells of one
   // pixel sit in different theta rows, so a read never meets a pending
   // write to the same entry.
   always_comb begin
      if (state_ff == hlvp_pkg::ST_IDLE) begin
         vram_raddr = {req_theta, req_rho};
      end else begin
         vram_raddr = {hit.theta, hit.rho};
      end
      if (state_ff == hlvp_pkg::ST_CLEAR) begin
         vram_we    = 1'b1;
         vram_waddr = clr_addr_ff;
         vram_wdata = '0;
      end else begin
         vram_we    = w_valid_ff;
         vram_waddr = w_addr_ff;
         vram_wdata = (vram_rdata == hlvp_pkg::VOTE_MAX) ? vram_rdata : vram_rdata + 16'd1;
      end
   end

   hlvp_vote_ram u_vote_ram (
      .clock (clock),
      .we    (vram_we),
      .waddr (vram_waddr),
      .wdata (vram_wdata),
      .raddr (vram_raddr),
      .rdata (vram_rdata)
   );

   // Next state, bookkeeping and response.
   always_comb begin
      state_in      = state_ff;
      issue_in      = issue_ff;
      x_in          = x_ff;
      y_in          = y_ff;
      scan_theta_in = scan_theta_ff;
      scan_rho_in   = scan_rho_ff;
      clr_addr_in   = clr_addr_ff;
      clr_report_in = clr_report_ff;
      drop_in       = drop_ff;
      best_votes_in = best_votes_ff;
      best_rho_in   = best_rho_ff;
      best_theta_in = best_theta_ff;
      rsp_valid_in  = 1'b0;
      votes         = '0;
      above         = 1'b0;
      srho          = '0;
      status        = hlvp_pkg::STATUS_OK;

      // Issue the cell leaving the pipeline; flag out-of-range rho.
      w_valid_in = hit.valid && hit.in_range;
      w_addr_in  = {hit.theta, hit.rho};
      if (hit.valid && !hit.in_range) begin
         drop_in = 1'b1;
      end

      case (state_ff)
         hlvp_pkg::ST_IDLE: begin
            if (accept) begin
               case (req_data.kind)
                  hlvp_pkg::KIND_LOAD: begin
                     rsp_valid_in = 1'b1;
                     status = req_load_ok ? hlvp_pkg::STATUS_OK : hlvp_pkg::STATUS_RANGE;
                  end
                  hlvp_pkg::KIND_VOTE: begin
                     x_in     = hlvp_pkg::COORD_BITS'(req_data.pixel_x);
                     y_in     = hlvp_pkg::COORD_BITS'(req_data.pixel_y);
                     issue_in = '0;
                     drop_in  = 1'b0;
                     if (na == '0) begin
                        rsp_valid_in = 1'b1;
                     end else begin
                        state_in = hlvp_pkg::ST_VOTE;
                     end
                  end
                  hlvp_pkg::KIND_SCAN: begin
                     scan_theta_in = req_theta;
                     scan_rho_in   = req_rho;
                     if (req_scan_ok) begin
                        state_in = hlvp_pkg::ST_SCAN;
                     end else begin
                        rsp_valid_in = 1'b1;
                        status       = hlvp_pkg::STATUS_RANGE;
                     end
                  end
                  hlvp_pkg::KIND_CLEAR: begin
                     best_votes_in = '0;
                     best_rho_in   = '0;
                     best_theta_in = '0;
                     clr_addr_in   = '0;
                     clr_report_in = 1'b1;
                     state_in      = hlvp_pkg::ST_CLEAR;
                  end
                  default: begin
                  end
               endcase
            end
         end
         hlvp_pkg::ST_CLEAR: begin
            // Advance one cell per cycle; report only for a requested clear.
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == '1) begin
               state_in      = hlvp_pkg::ST_IDLE;
               rsp_valid_in  = clr_report_ff;
               clr_report_in = 1'b0;
            end
         end
         hlvp_pkg::ST_VOTE: begin
            issue_in = issue_ff + 1'b1;
            if ((32'(issue_ff) + 1) == 32'(na)) begin
               state_in = hlvp_pkg::ST_DRAIN;
            end
         end
         hlvp_pkg::ST_DRAIN: begin
            // Hold the response until the last write has landed.
            if (!pipe_busy) begin
               state_in     = hlvp_pkg::ST_IDLE;
               rsp_valid_in = 1'b1;
               status = drop_ff ? hlvp_pkg::STATUS_DROPPED : hlvp_pkg::STATUS_OK;
            end
         end
         hlvp_pkg::ST_SCAN: begin
            votes = vram_rdata;
            srho  = $signed(12'(scan_rho_ff)) - $signed(12'(half));
            above = votes > vote_threshold_ff;
            if (above && (votes > best_votes_ff)) begin
               best_votes_in = votes;
               best_rho_in   = scan_rho_ff;
               best_theta_in = scan_theta_ff;
            end
            rsp_valid_in = 1'b1;
            state_in     = hlvp_pkg::ST_IDLE;
         end
         default: begin
            state_in = hlvp_pkg::ST_IDLE;
         end
      endcase

      rsp_in.votes           = votes;
      rsp_in.above_threshold = above;
      rsp_in.best_votes      = best_votes_in;
      rsp_in.best_rho        = 11'(best_rho_in);
      rsp_in.best_theta      = 8'(best_theta_in);
      rsp_in.signed_rho_bin  = srho;
      rsp_in.status          = status;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= hlvp_pkg::ST_CLEAR;
         clr_addr_ff   <= '0;
         clr_report_ff <= 1'b0;
         best_votes_ff <= '0;
         best_rho_ff   <= '0;
         best_theta_ff <= '0;
         w_valid_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         drop_ff       <= 1'b0;
         issue_ff      <= '0;
      end else begin
         state_ff      <= state_in;
         clr_addr_ff   <= clr_addr_in;
         clr_report_ff <= clr_report_in;
         best_votes_ff <= best_votes_in;
         best_rho_ff   <= best_rho_in;
         best_theta_ff <= best_theta_in;
         w_valid_ff    <= w_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         drop_ff       <= drop_in;
         issue_ff      <= issue_in;
      end
      x_ff          <= x_in;
      y_ff          <= y_in;
      scan_theta_ff <= scan_theta_in;
      scan_rho_ff   <= scan_rho_in;
      w_addr_ff     <= w_addr_in;
      rsp_ff        <= rsp_in;
   end

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         angle_count_ff    <= hlvp_pkg::ANGLE_COUNT_RST;
         rho_count_ff      <= hlvp_pkg::RHO_COUNT_RST;
         inv_rho_step_ff   <= hlvp_pkg::INV_RHO_STEP_RST;
         vote_threshold_ff <= hlvp_pkg::VOTE_THRESHOLD_RST;
      end else if (csr_we) begin
         case (csr_index)
            hlvp_pkg::CSR_ANGLE_COUNT:    angle_count_ff    <= csr_wdata[8:0];
            hlvp_pkg::CSR_RHO_COUNT:      rho_count_ff      <= csr_wdata[11:0];
            hlvp_pkg::CSR_INV_RHO_STEP:   inv_rho_step_ff   <= csr_wdata;
            hlvp_pkg::CSR_VOTE_THRESHOLD: vote_threshold_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // A response only follows work in progress or a request just taken.
   a_rsp_has_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(busy || accept))
      else $error("response without a request");

   // The rho pipeline is empty whenever the block can take a request.
   a_idle_pipe_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == hlvp_pkg::ST_IDLE) |-> !pipe_busy)
      else $error("pipeline busy while idle");

   // An increment never wraps a count back to zero.
   a_no_wrap: assert property (@(posedge clock) disable iff (reset)
      (vram_we && (state_ff != hlvp_pkg::ST_CLEAR)) |-> (vram_wdata != '0))
      else $error("vote count wrapped");

   // The tracker only grows between clears.
   a_best_monotonic: assert property (@(posedge clock) disable iff (reset)
      (state_ff == hlvp_pkg::ST_SCAN) |=> (best_votes_ff >= $past(best_votes_ff)))
      else $error("best count decreased on scan");

endmodule

### verif/hough_line_vote_and_peak_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hough_line_vote_and_peak_tb
// Self-checking bench for the Hough line voting engine: fills the angle table,
// walks a directed table of requests, then runs randomized phases under
// several register settings and idle patterns. Each response is checked by
// field against a typed value or an in-bench accumulator and tracker model.
// ----------------------------------------------------------------------------
module hough_line_vote_and_peak_tb;

   localparam int  HALF_PERIOD = 10;
   localparam int  PHASES      = 8;
   localparam int  PHASE_ITEMS = 150;
   // Take several times the slowest run: the reset sweep, a clear or a vote
   // at full angle count.
   localparam longint CYCLE_LIMIT = 64'd6_000_000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   hlvp_pkg::req_type req_data = '0;
   logic    rsp_valid;
   hlvp_pkg::rsp_type rsp_data;
   logic    csr_we = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [15:0] csr_wdata = '0;

   hough_line_vote_and_peak dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #HALF_PERIOD clock = ~clock;

   // ---- model state: sparse accumulator, angle table, tracker, registers ----
   logic [15:0] cell_votes[int];
   int          trig_cos[hlvp_pkg::THETA_BINS];
   int          trig_sin[hlvp_pkg::THETA_BINS];
   logic [15:0] peak_votes;
   logic [10:0] peak_rho;
   logic [7:0]  peak_theta;
   logic [8:0]  reg_angles;
   logic [11:0] reg_rhos;
   logic [15:0] reg_inv_step;
   logic [15:0] reg_threshold;
   // last cell that took a vote, so scans can aim at live cells
   int          hot_theta;
   int          hot_rho;

   hlvp_pkg::rsp_type pending_rsp[$];
   int      fail_count = 0;
   longint  cycle_count = 0;
   int      idle_pct = 0;

   // Timeout guard.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL hough_line_vote_and_peak");
         $finish;
      end
   end

   task automatic check_field(string name, longint exp_v, longint act_v);
      if (exp_v != act_v) begin
         $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
         fail_count++;
      end
   endtask

   // Sample responses mid-cycle, away from the edge the block updates on.
   always @(negedge clock) begin
      hlvp_pkg::rsp_type want;
      if (!reset && rsp_valid) begin
         if (pending_rsp.size() == 0) begin
            $error("response with no request outstanding");
            fail_count++;
         end else begin
            want = pending_rsp.pop_front();
            check_field("votes", want.votes, rsp_data.votes);
            check_field("above_threshold", want.above_threshold, rsp_data.above_threshold);
            check_field("best_votes", want.best_votes, rsp_data.best_votes);
            check_field("best_rho", want.best_rho, rsp_data.best_rho);
            check_field("best_theta", want.best_theta, rsp_data.best_theta);
            check_field("signed_rho_bin", want.signed_rho_bin, rsp_data.signed_rho_bin);
            check_field("status", want.status, rsp_data.status);
         end
      end
   end

   // Advance the accumulator model by one request and return its response.
   function automatic hlvp_pkg::rsp_type vote_engine(hlvp_pkg::req_type q);
      hlvp_pkg::rsp_type res;
      longint  na, nr, half, x, y, rho, scaled, idx;
      int      t, r, key;
      logic [15:0] v;
      res = '0;
      na = (reg_angles > hlvp_pkg::THETA_BINS) ? hlvp_pkg::THETA_BINS : reg_angles;
      nr = (reg_rhos > hlvp_pkg::RHO_BINS) ? hlvp_pkg::RHO_BINS : reg_rhos;
      half = nr / 2;
      case (hlvp_pkg::kind_type'(q.kind))
         hlvp_pkg::KIND_LOAD: begin
            trig_cos[q.angle_index] = q.cos_value;
            trig_sin[q.angle_index] = q.sin_value;
         end
         hlvp_pkg::KIND_VOTE: begin
            x = q.pixel_x;
            y = q.pixel_y;
            for (t = 0; t < na; t++) begin
               rho = x * trig_cos[t] + y * trig_sin[t];
               scaled = rho * longint'(reg_inv_step);
               // arithmetic shift floors, giving round-half-up
               idx = ((scaled + (64'sd1 <<< (hlvp_pkg::SCALE_SHIFT - 1)))
                      >>> hlvp_pkg::SCALE_SHIFT) + half;
               if (idx < 0 || idx >= nr) begin
                  res.status = hlvp_pkg::STATUS_DROPPED;
               end else begin
                  key = t * hlvp_pkg::RHO_BINS + int'(idx);
                  v = cell_votes.exists(key) ? cell_votes[key] : 16'd0;
                  if (v != hlvp_pkg::VOTE_MAX) cell_votes[key] = v + 16'd1;
                  hot_theta = t;
                  hot_rho = int'(idx);
               end
            end
         end
         hlvp_pkg::KIND_SCAN: begin
            t = q.angle_index;
            r = q.cell_rho;
            if (t >= na || r >= nr) begin
               res.status = hlvp_pkg::STATUS_RANGE;
            end else begin
               key = t * hlvp_pkg::RHO_BINS + r;
               res.votes = cell_votes.exists(key) ? cell_votes[key] : 16'd0;
               res.signed_rho_bin = 12'(r - int'(half));
               if (res.votes > reg_threshold) begin
                  res.above_threshold = 1'b1;
                  if (res.votes > peak_votes) begin
                     peak_votes = res.votes;
                     peak_rho = 11'(r);
                     peak_theta = 8'(t);
                  end
               end
            end
         end
         default: begin
            cell_votes.delete();
            peak_votes = '0;
            peak_rho = '0;
            peak_theta = '0;
         end
      endcase
      res.best_votes = peak_votes;
      res.best_rho = peak_rho;
      res.best_theta = peak_theta;
      return res;
   endfunction

   function automatic hlvp_pkg::req_type make_req(hlvp_pkg::kind_type k, int x, int y,
                                                  int a, int c, int s, int rho);
      hlvp_pkg::req_type q;
      q.kind = k;
      q.pixel_x = 9'(x);
      q.pixel_y = 9'(y);
      q.angle_index = 8'(a);
      q.cos_value = 16'(c);
      q.sin_value = 16'(s);
      q.cell_rho = 11'(rho);
      return q;
   endfunction

   function automatic hlvp_pkg::rsp_type make_rsp(int votes, int srho,
                                                  hlvp_pkg::status_type st);
      hlvp_pkg::rsp_type r;
      r = '0;
      r.votes = 16'(votes);
      r.signed_rho_bin = 12'(srho);
      r.status = st;
      return r;
   endfunction

   // Issue one request; hold it until taken, then queue its expected response.
   // Called right after a rising edge, returns right after one.
   task automatic issue(hlvp_pkg::req_type q, bit typed, hlvp_pkg::rsp_type typed_rsp,
                        int gap);
      bit      taken;
      hlvp_pkg::rsp_type model_rsp;
      start <= 1'b1;
      req_data <= q;
      do begin
         @(negedge clock);
         taken = !busy;
         @(posedge clock);
      end while (!taken);
      model_rsp = vote_engine(q);
      pending_rsp.insert(pending_rsp.size(), typed ? typed_rsp : model_rsp);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Drop start and hold until every response is back.
   task automatic drain_responses();
      start <= 1'b0;
      @(posedge clock);
      while (pending_rsp.size() != 0) @(posedge clock);
   endtask

   task automatic program_regs(int ac, int rc, int inv, int thr);
      int vals[4];
      vals = '{ac, rc, inv, thr};
      csr_we <= 1'b1;
      for (int i = 0; i < 4; i++) begin
         csr_index <= hlvp_pkg::csr_index_type'(i);
         csr_wdata <= 16'(vals[i]);
         @(posedge clock);
      end
      csr_we <= 1'b0;
      reg_angles = 9'(ac);
      reg_rhos = 12'(rc);
      reg_inv_step = 16'(inv);
      reg_threshold = 16'(thr);
      @(posedge clock);
   endtask

   function automatic int pick_gap();
      if (idle_pct == 0 || $urandom_range(99) >= idle_pct) return 0;
      return $urandom_range(1, 6);
   endfunction

   // Random request: mostly votes and scans aimed at the populated region.
   function automatic hlvp_pkg::req_type random_req();
      hlvp_pkg::req_type q;
      int      pick, na, nr;
      q = hlvp_pkg::req_type'($bits(hlvp_pkg::req_type)'({$urandom, $urandom, $urandom}));
      na = (reg_angles > hlvp_pkg::THETA_BINS) ? hlvp_pkg::THETA_BINS : reg_angles;
      nr = (reg_rhos > hlvp_pkg::RHO_BINS) ? hlvp_pkg::RHO_BINS : reg_rhos;
      pick = $urandom_range(99);
      if (pick < 10) begin
         q.kind = hlvp_pkg::KIND_LOAD;
         if ($urandom_range(1)) begin
            q.cos_value = 16'($urandom_range(32768) - 16384);
            q.sin_value = 16'($urandom_range(32768) - 16384);
         end
      end else if (pick < 60) begin
         q.kind = hlvp_pkg::KIND_VOTE;
         // a small pixel pool piles votes onto the same cells
         if ($urandom_range(1)) begin
            q.pixel_x = 9'($urandom_range(3));
            q.pixel_y = 9'($urandom_range(3));
         end
      end else begin
         q.kind = hlvp_pkg::KIND_SCAN;
         if (pick < 80 && na > 0 && nr > 0) begin
            q.angle_index = 8'(hot_theta);
            q.cell_rho = 11'(hot_rho);
         end else if (pick < 92 && na > 0 && nr > 0) begin
            q.angle_index = 8'($urandom_range(na - 1));
            q.cell_rho = 11'($urandom_range(nr - 1));
         end
      end
      return q;
   endfunction

   typedef struct {
      hlvp_pkg::req_type q;
      bit                typed;
      hlvp_pkg::rsp_type r;
   } plan_row_type;

   function automatic plan_row_type plan_row(hlvp_pkg::req_type q, bit typed,
                                             hlvp_pkg::rsp_type r);
      plan_row_type row;
      row.q = q;
      row.typed = typed;
      row.r = r;
      return row;
   endfunction

   initial begin
      plan_row_type      plan[$];
      hlvp_pkg::rsp_type none;
      int phase_cfg[PHASES][4];
      none = '0;
      peak_votes = '0;
      peak_rho = '0;
      peak_theta = '0;
      hot_theta = 0;
      hot_rho = 0;
      reg_angles = hlvp_pkg::ANGLE_COUNT_RST;
      reg_rhos = hlvp_pkg::RHO_COUNT_RST;
      reg_inv_step = hlvp_pkg::INV_RHO_STEP_RST;
      reg_threshold = hlvp_pkg::VOTE_THRESHOLD_RST;

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Fill the whole angle table so no vote ever reads an unwritten entry.
      for (int a = 0; a < hlvp_pkg::THETA_BINS; a++)
         issue(make_req(hlvp_pkg::KIND_LOAD, 0, 0, a, $urandom_range(32768) - 16384,
                        $urandom_range(32768) - 16384, 0), 1'b0, none, 0);

      // Directed table at reset register values (180 angles, 1447 bins).
      plan.insert(plan.size(), plan_row(make_req(hlvp_pkg::KIND_SCAN, 0, 0, 0, 0, 0, 0), 1,
                                        make_rsp(0, -723, hlvp_pkg::STATUS_OK)));
      plan.insert(plan.size(), plan_row(make_req(hlvp_pkg::KIND_SCAN, 0, 0, 180, 0, 0, 0), 1,
                                        make_rsp(0, 0, hlvp_pkg::STATUS_RANGE)));
      plan.insert(plan.size(), plan_row(make_req(hlvp_pkg::KIND_SCAN, 0, 0, 0, 0, 0, 1447), 1,
                                        make_rsp(0, 0, hlvp_pkg::STATUS_RANGE)));
      plan.insert(plan.size(),
                  plan_row(make_req(hlvp_pkg::KIND_SCAN, 511, 511, 255, -1, -1, 2047), 1,
                           make_rsp(0, 0, hlvp_pkg::STATUS_RANGE)));
      plan.insert(plan.size(),
                  plan_row(make_req(hlvp_pkg::KIND_LOAD, 0, 0, 0, 16384, 0, 0), 1, none));
      plan.insert(plan.size(),
                  plan_row(make_req(hlvp_pkg::KIND_LOAD, 0, 0, 1, -16384, 16384, 0), 1, none));
      plan.insert(plan.size(),
                  plan_row(make_req(hlvp_pkg::KIND_LOAD, 0, 0, 2, 32767, -32768, 0), 1, none));
      plan.insert(plan.size(),
                  plan_row(make_req(hlvp_pkg::KIND_LOAD, 0, 0, 255, 0, 16384, 0), 1, none));
      plan.insert(plan.size(),
                  plan_row(make_req(hlvp_pkg::KIND_VOTE, 0, 0, 0, 0, 0, 0), 0, none));
      plan.insert(plan.size(),
                  plan_row(make_req(hlvp_pkg::KIND_VOTE, 511, 511, 0, 0, 0, 0), 0, none));
      plan.insert(plan.size(),
                  plan_row(make_req(hlvp_pkg::KIND_VOTE, 511, 0, 0, 0, 0, 0), 0, none));
      plan.insert(plan.size(),
                  plan_row(make_req(hlvp_pkg::KIND_VOTE, 0, 511, 0, 0, 0, 0), 0, none));
      plan.insert(plan.size(),
                  plan_row(make_req(hlvp_pkg::KIND_SCAN, 0, 0, 0, 0, 0, 723), 0, none));
      plan.insert(plan.size(),
                  plan_row(make_req(hlvp_pkg::KIND_SCAN, 0, 0, 0, 0, 0, 1234), 0, none));
      plan.insert(plan.size(),
                  plan_row(make_req(hlvp_pkg::KIND_SCAN, 0, 0, 1, 0, 0, 723), 0, none));
      plan.insert(plan.size(),
                  plan_row(make_req(hlvp_pkg::KIND_CLEAR, 0, 0, 0, 0, 0, 0), 1, none));
      plan.insert(plan.size(), plan_row(make_req(hlvp_pkg::KIND_SCAN, 0, 0, 0, 0, 0, 723), 1,
                                        make_rsp(0, 0, hlvp_pkg::STATUS_OK)));
      plan.insert(plan.size(),
                  plan_row(make_req(hlvp_pkg::KIND_SCAN, 0, 0, 179, 0, 0, 1446), 1,
                           make_rsp(0, 723, hlvp_pkg::STATUS_OK)));
      // after the clear, the typed scan at rho 723 has signed bin 0
      foreach (plan[i]) issue(plan[i].q, plan[i].typed, plan[i].r, pick_gap());
      drain_responses();

      // Register settings per phase: extremes plus small working sizes.
      phase_cfg = '{'{8, 2048, 256, 1}, '{0, 1447, 256, 0},
                    '{511, 4095, 65535, 65535}, '{4, 0, 1, 0},
                    '{1, 1, 0, 0}, '{256, 64, 16, 3},
                    '{12, 300, 200, 2}, '{6, 2047, 4000, 5}};
      for (int p = 0; p < PHASES; p++) begin
         program_regs(phase_cfg[p][0], phase_cfg[p][1], phase_cfg[p][2], phase_cfg[p][3]);
         case (p % 4)
            0: idle_pct = 0;
            1: idle_pct = 48;
            2: idle_pct = 0;
            default: idle_pct = 35;
         endcase
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // once mid-run, pause until the block has answered everything
            if (p == 3 && n == PHASE_ITEMS / 2) begin
               drain_responses();
            end
            issue(random_req(), 1'b0, none, pick_gap());
         end
         drain_responses();
      end

      repeat (20) @(posedge clock);
      if (fail_count == 0) begin
         $display("PASS hough_line_vote_and_peak");
      end else begin
         $display("FAIL hough_line_vote_and_peak");
      end
      $finish;
   end

endmodule
